>>> hdl/cstir_pkg.sv
`timescale 1ns / 1ps

package cstir_pkg;

	// table geometry
	localparam int SLOTS  = 64;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);

	// fixed field widths of the result
	localparam int ID_W   = 6;
	localparam int OCNT_W = 7;
	localparam int TIME_W = 32;
	localparam int TOT_W  = 32;

	localparam logic [TIME_W-1:0] TIMEOUT_RESET = TIME_W'(30000);

	typedef enum logic [1:0] {
		OP_ACCEPT = 2'd0,
		OP_CLOSE  = 2'd1,
		OP_TOUCH  = 2'd2,
		OP_REAP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FREE  = 2'd1,
		ST_RANGE    = 2'd2,
		ST_NOT_USED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_LAUNCH,
		S_SWEEP,
		S_FINISH
	} state_t;

	// broadcast from control to every cell
	typedef struct packed {
		logic              sweep_acc;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] timeout;
		logic              clr;
		logic              touch;
		logic [SLOT_W-1:0] sel;
	} cmd_t;

	// token handed from one cell to the next
	typedef struct packed {
		logic              go;
		logic              found;
		logic [SLOT_W-1:0] grant;
		logic [CNT_W-1:0]  cnt;
	} link_t;

endpackage

>>> hdl/cstir_cell.sv
`timescale 1ns / 1ps

module cstir_cell
	import cstir_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] cell_idx,
	input  cmd_t              cmd,
	input  link_t             link_in,
	output link_t             link_out,
	output logic              valid
);

	logic              valid_q;
	logic [TIME_W-1:0] stamp_q;
	link_t             link_q;

	logic hit;
	logic claim;
	logic expire;
	logic [TIME_W-1:0] idle;

	// decide what this cell does with the passing token
	always_comb begin
		hit    = (cmd.sel == cell_idx);
		claim  = link_in.go && cmd.sweep_acc && !link_in.found && !valid_q;
		idle   = cmd.now - stamp_q;
		expire = link_in.go && !cmd.sweep_acc && valid_q &&
			(cmd.now >= stamp_q) && (idle > cmd.timeout);
	end

	// hold slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (claim) begin
			valid_q <= 1'b1;
		end else if (expire || (cmd.clr && hit)) begin
			valid_q <= 1'b0;
		end
	end

	// restamp on claim or touch
	always_ff @(posedge clk) begin
		if (claim || (cmd.touch && hit)) begin
			stamp_q <= cmd.now;
		end
	end

	// advance the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q.go    <= link_in.go;
			link_q.found <= link_in.found | claim;
			link_q.grant <= claim ? cell_idx : link_in.grant;
			link_q.cnt   <= link_in.cnt + CNT_W'(expire);
		end
	end

	assign link_out = link_q;
	assign valid    = valid_q;

endmodule

>>> hdl/cstir_ctrl.sv
`timescale 1ns / 1ps

module cstir_ctrl
	import cstir_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [7:0]        conn_slot,
	input  logic [31:0]       now_time,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [ID_W-1:0]   slot_id,
	output logic [OCNT_W-1:0] reaped_count,
	output logic [OCNT_W-1:0] open_count,
	output logic [TOT_W-1:0]  accepted_total,
	output logic [TOT_W-1:0]  rejected_total,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	input  logic [SLOTS-1:0]  valid_vec,
	input  link_t             link_tail,
	output link_t             link_head,
	output cmd_t              cmd
);

	function automatic logic [ID_W-1:0] to_id(input logic [SLOT_W-1:0] g);
		logic [ID_W+SLOT_W-1:0] w;
		begin
			w = (ID_W + SLOT_W)'(g);
			return w[ID_W-1:0];
		end
	endfunction

	function automatic logic [OCNT_W-1:0] to_ocnt(input logic [CNT_W-1:0] c);
		logic [OCNT_W+CNT_W-1:0] w;
		begin
			w = (OCNT_W + CNT_W)'(c);
			return w[OCNT_W-1:0];
		end
	endfunction

	state_t state_q, state_nx;

	op_t               op_q;
	logic [7:0]        slot_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] timeout_q;
	logic [CNT_W-1:0]  open_q;
	logic [TOT_W-1:0]  acc_q;
	logic [TOT_W-1:0]  rej_q;

	status_t           res_status_q;
	logic [SLOT_W-1:0] res_id_q;
	logic [CNT_W-1:0]  res_reap_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [ID_W-1:0]   out_id_q;
	logic [OCNT_W-1:0] out_reap_q;
	logic [OCNT_W-1:0] out_open_q;
	logic [TOT_W-1:0]  out_acc_q;
	logic [TOT_W-1:0]  out_rej_q;

	logic in_range;
	logic slot_used;
	logic out_free;
	logic take;

	// check the addressed slot of a close or touch request
	always_comb begin
		in_range  = (32'(slot_q) < SLOTS);
		slot_used = in_range && valid_vec[slot_q[SLOT_W-1:0]];
		out_free  = !out_valid_q || out_ready;
		take      = in_valid && in_ready;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op_t'(op) == OP_ACCEPT || op_t'(op) == OP_REAP) begin
						state_nx = S_LAUNCH;
					end else begin
						state_nx = S_EXEC;
					end
				end
			end
			S_EXEC:   state_nx = S_FINISH;
			S_LAUNCH: state_nx = S_SWEEP;
			S_SWEEP: begin
				if (link_tail.go) begin
					state_nx = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		in_ready        = (state_q == S_IDLE);
		link_head       = '0;
		link_head.go    = (state_q == S_LAUNCH);
		cmd.sweep_acc   = (op_q == OP_ACCEPT);
		cmd.now         = now_q;
		cmd.timeout     = timeout_q;
		cmd.sel         = slot_q[SLOT_W-1:0];
		cmd.clr         = (state_q == S_EXEC) && (op_q == OP_CLOSE) && slot_used;
		cmd.touch       = (state_q == S_EXEC) && (op_q == OP_TOUCH) && slot_used;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// latch the request
	always_ff @(posedge clk) begin
		if (take) begin
			op_q   <= op_t'(op);
			slot_q <= conn_slot;
			now_q  <= now_time;
		end
	end

	// hold the timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// update counters and stage the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			acc_q  <= '0;
			rej_q  <= '0;
		end else if (state_q == S_EXEC) begin
			if (cmd.clr) begin
				open_q <= open_q - CNT_W'(1);
			end
		end else if (state_q == S_SWEEP && link_tail.go) begin
			if (op_q == OP_ACCEPT) begin
				if (link_tail.found) begin
					open_q <= open_q + CNT_W'(1);
					acc_q  <= acc_q + TOT_W'(1);
				end else begin
					rej_q <= rej_q + TOT_W'(1);
				end
			end else begin
				open_q <= open_q - link_tail.cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			res_id_q   <= '0;
			res_reap_q <= '0;
			if (!in_range) begin
				res_status_q <= ST_RANGE;
			end else if (!slot_used) begin
				res_status_q <= ST_NOT_USED;
			end else begin
				res_status_q <= ST_OK;
			end
		end else if (state_q == S_SWEEP && link_tail.go) begin
			if (op_q == OP_ACCEPT) begin
				res_reap_q <= '0;
				if (link_tail.found) begin
					res_status_q <= ST_OK;
					res_id_q     <= link_tail.grant;
				end else begin
					res_status_q <= ST_NO_FREE;
					res_id_q     <= '0;
				end
			end else begin
				res_status_q <= ST_OK;
				res_id_q     <= '0;
				res_reap_q   <= link_tail.cnt;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FINISH && out_free) begin
			out_status_q <= res_status_q;
			out_id_q     <= to_id(res_id_q);
			out_reap_q   <= to_ocnt(res_reap_q);
			out_open_q   <= to_ocnt(open_q);
			out_acc_q    <= acc_q;
			out_rej_q    <= rej_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign slot_id        = out_id_q;
	assign reaped_count   = out_reap_q;
	assign open_count     = out_open_q;
	assign accepted_total = out_acc_q;
	assign rejected_total = out_rej_q;

endmodule

>>> hdl/connection_slot_table_idle_reap.sv
`timescale 1ns / 1ps

// Connection slot table with idle-timeout reaping. Each slot lives in a cell of a
// chain of SLOTS cells that holds its valid bit and last-activity stamp. A close or
// touch request addresses its slot directly and goes through the EXEC and FINISH
// states before its result is registered. An accept or reap request sends a token
// down the chain, one cell per cycle: the first free cell claims an accept, and each
// expired cell adds itself to the reap count as the token passes. Those requests go
// through LAUNCH, SWEEP while the token walks the chain, and FINISH. One request is
// worked on at a time; a finished result waits in the output register while the next
// request is taken. idle_timeout resets to 30000 and is written through cfg_we /
// cfg_wdata by the user only while the block is idle; the block does not enforce this.

module connection_slot_table_idle_reap
	import cstir_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        op,
	input  logic [7:0]        conn_slot,
	input  logic [31:0]       now_time,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [ID_W-1:0]   slot_id,
	output logic [OCNT_W-1:0] reaped_count,
	output logic [OCNT_W-1:0] open_count,
	output logic [TOT_W-1:0]  accepted_total,
	output logic [TOT_W-1:0]  rejected_total,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata
);

	link_t            link [SLOTS+1];
	cmd_t             cmd;
	logic [SLOTS-1:0] valid_vec;

	cstir_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.conn_slot      (conn_slot),
		.now_time       (now_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.slot_id        (slot_id),
		.reaped_count   (reaped_count),
		.open_count     (open_count),
		.accepted_total (accepted_total),
		.rejected_total (rejected_total),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.valid_vec      (valid_vec),
		.link_tail      (link[SLOTS]),
		.link_head      (link[0]),
		.cmd            (cmd)
	);

	// chain of slot cells
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		cstir_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (SLOT_W'(i)),
			.cmd      (cmd),
			.link_in  (link[i]),
			.link_out (link[i+1]),
			.valid    (valid_vec[i])
		);
	end

endmodule

>>> sim/connection_slot_table_idle_reap_tb.sv
`timescale 1ns / 1ps

module connection_slot_table_idle_reap_tb;
	import cstir_pkg::*;

	typedef struct {
		status_t           status;
		logic [ID_W-1:0]   slot_id;
		logic [OCNT_W-1:0] reaped_count;
		logic [OCNT_W-1:0] open_count;
		logic [TOT_W-1:0]  accepted_total;
		logic [TOT_W-1:0]  rejected_total;
	} table_reply_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              in_valid       = 1'b0;
	logic              in_ready;
	logic [1:0]        op             = OP_ACCEPT;
	logic [7:0]        conn_slot      = '0;
	logic [31:0]       now_time       = '0;
	logic              out_valid;
	logic              out_ready      = 1'b0;
	logic [1:0]        status;
	logic [ID_W-1:0]   slot_id;
	logic [OCNT_W-1:0] reaped_count;
	logic [OCNT_W-1:0] open_count;
	logic [TOT_W-1:0]  accepted_total;
	logic [TOT_W-1:0]  rejected_total;
	logic              cfg_we         = 1'b0;
	logic [31:0]       cfg_wdata      = '0;

	// predicted table contents
	bit                slot_open [SLOTS];
	logic [TIME_W-1:0] slot_stamp [SLOTS];
	int unsigned       open_total   = 0;
	logic [TOT_W-1:0]  accept_total = '0;
	logic [TOT_W-1:0]  reject_total = '0;
	logic [TIME_W-1:0] idle_limit   = TIMEOUT_RESET;

	table_reply_t      table_replies [$];
	int                mismatch_count = 0;
	bit                no_gaps        = 1'b0;
	logic [TIME_W-1:0] clock_ms       = '0;

	connection_slot_table_idle_reap u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.conn_slot      (conn_slot),
		.now_time       (now_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.slot_id        (slot_id),
		.reaped_count   (reaped_count),
		.open_count     (open_count),
		.accepted_total (accepted_total),
		.rejected_total (rejected_total),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// apply one request to the predicted table and return its reply
	function automatic table_reply_t apply_table_request(op_t req_op, logic [7:0] req_slot,
			logic [TIME_W-1:0] req_time);
		table_reply_t      r;
		logic [TIME_W-1:0] idle;
		int unsigned       freed;
		int                free_idx;
		r = '{ST_OK, '0, '0, '0, '0, '0};
		freed = 0;
		free_idx = -1;
		case (req_op)
			OP_ACCEPT: begin
				for (int i = 0; i < SLOTS; i++)
					if (!slot_open[i] && free_idx < 0)
						free_idx = i;
				if (free_idx < 0) begin
					reject_total++;
					r.status = ST_NO_FREE;
				end else begin
					slot_open[free_idx] = 1'b1;
					slot_stamp[free_idx] = req_time;
					open_total++;
					accept_total++;
					r.slot_id = ID_W'(free_idx);
				end
			end
			OP_CLOSE, OP_TOUCH: begin
				if (req_slot >= SLOTS) begin
					r.status = ST_RANGE;
				end else if (!slot_open[req_slot]) begin
					r.status = ST_NOT_USED;
				end else if (req_op == OP_CLOSE) begin
					slot_open[req_slot] = 1'b0;
					if (open_total > 0)
						open_total--;
				end else begin
					slot_stamp[req_slot] = req_time;
				end
			end
			default: begin
				// a stamp ahead of the clock counts as no idle time
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_open[i]) begin
						idle = (req_time >= slot_stamp[i]) ? req_time - slot_stamp[i] : '0;
						if (idle > idle_limit) begin
							slot_open[i] = 1'b0;
							if (open_total > 0)
								open_total--;
							freed++;
						end
					end
				end
			end
		endcase
		r.reaped_count   = OCNT_W'(freed);
		r.open_count     = OCNT_W'(open_total);
		r.accepted_total = accept_total;
		r.rejected_total = reject_total;
		return r;
	endfunction

	// move the stimulus clock: mostly forward, sometimes back or anywhere
	function automatic logic [TIME_W-1:0] advance_clock(int unsigned max_step);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			clock_ms -= $urandom_range(0, 2 * max_step);
		else if (pick < 6)
			clock_ms = $urandom;
		else
			clock_ms += $urandom_range(0, max_step);
		return clock_ms;
	endfunction

	// mostly a slot in use, sometimes any slot number at all
	function automatic logic [7:0] pick_conn_slot();
		int unsigned pick;
		int unsigned start;
		pick = $urandom_range(0, 99);
		start = $urandom_range(0, SLOTS - 1);
		if (pick < 10)
			return 8'($urandom_range(0, 255));
		if (pick < 20)
			return 8'(start);
		for (int k = 0; k < SLOTS; k++)
			if (slot_open[(start + k) % SLOTS])
				return 8'((start + k) % SLOTS);
		return 8'(start);
	endfunction

	function automatic op_t pick_op();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			return OP_ACCEPT;
		if (pick < 50)
			return OP_CLOSE;
		if (pick < 85)
			return OP_TOUCH;
		return OP_REAP;
	endfunction

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// present one request, hold it until taken, then log its expected reply
	task automatic send_request(op_t req_op, logic [7:0] req_slot, logic [TIME_W-1:0] req_time);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= req_op;
		conn_slot <= req_slot;
		now_time  <= req_time;
		do @(posedge clk); while (!in_ready);
		table_replies.push_back(apply_table_request(req_op, req_slot, req_time));
	endtask

	// drop valid and wait until every reply is back
	task automatic wait_for_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (table_replies.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_idle_timeout(logic [TIME_W-1:0] value);
		wait_for_replies();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		idle_limit = value;
	endtask

	// field extremes, the OK, range and not-used statuses, and the timeout boundary at the reset timeout
	task automatic test_directed_cases();
		send_request(OP_ACCEPT, 8'h00, 32'hFFFF_FFFF);
		send_request(OP_ACCEPT, 8'hFF, 32'h0000_0000);
		send_request(OP_ACCEPT, 8'h00, 32'd100);
		send_request(OP_TOUCH,  8'hFF, 32'd1);
		send_request(OP_CLOSE,  8'd64, 32'd1);
		send_request(OP_TOUCH,  8'd63, 32'd1);
		send_request(OP_CLOSE,  8'd3,  32'd1);
		send_request(OP_TOUCH,  8'd1,  32'd5);
		// stamps ahead of now count as zero idle
		send_request(OP_REAP,   8'h00, 32'd10);
		// idle equal to the timeout stays, one more frees it
		send_request(OP_REAP,   8'hFF, 32'd30005);
		send_request(OP_REAP,   8'h55, 32'd30006);
		send_request(OP_TOUCH,  8'd1,  32'd7);
		send_request(OP_CLOSE,  8'd0,  32'd0);
		send_request(OP_CLOSE,  8'd0,  32'd0);
		send_request(OP_ACCEPT, 8'hAA, 32'd40000);
		send_request(OP_REAP,   8'h00, 32'hFFFF_FFFF);
		send_request(OP_ACCEPT, 8'h3F, 32'd500);
	endtask

	// fill every slot, reject a few accepts, then reap the whole table at once
	task automatic test_table_full();
		op_t req_op;
		write_idle_timeout(32'hFFFF_FFFF);
		clock_ms = 32'd1000;
		for (int n = 0; n < 120; n++) begin
			req_op = ($urandom_range(0, 99) < 75) ? OP_ACCEPT :
				($urandom_range(0, 1) != 0) ? OP_CLOSE : OP_TOUCH;
			clock_ms += $urandom_range(0, 20);
			send_request(req_op, pick_conn_slot(), clock_ms);
		end
		while (open_total < SLOTS)
			send_request(OP_ACCEPT, 8'($urandom_range(0, 255)), clock_ms);
		repeat (3)
			send_request(OP_ACCEPT, 8'($urandom_range(0, 255)), clock_ms);
		send_request(OP_REAP, 8'h00, clock_ms);
		write_idle_timeout(32'd0);
		send_request(OP_REAP, 8'h00, clock_ms + 1);
	endtask

	// random traffic under one timeout, with a back-to-back stretch and a full drain
	task automatic test_churn(logic [TIME_W-1:0] timeout, int unsigned max_step, int items);
		write_idle_timeout(timeout);
		for (int n = 0; n < items; n++) begin
			no_gaps = (n >= items / 4) && (n < items / 4 + 40);
			if (n == items / 2)
				wait_for_replies();
			send_request(pick_op(), pick_conn_slot(), advance_clock(max_step));
		end
		no_gaps = 1'b0;
	endtask

	// check each reply against the oldest expectation
	initial begin : reply_checker
		table_reply_t want;
		int           stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (table_replies.size() == 0) begin
				$error("reply with no request outstanding");
				mismatch_count++;
			end else begin
				want = table_replies.pop_front();
				compare_field("status",         want.status,         status);
				compare_field("slot_id",        want.slot_id,        slot_id);
				compare_field("reaped_count",   want.reaped_count,   reaped_count);
				compare_field("open_count",     want.open_count,     open_count);
				compare_field("accepted_total", want.accepted_total, accepted_total);
				compare_field("rejected_total", want.rejected_total, rejected_total);
			end
		end
	end

	initial begin : run_limit
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_table_full();
		test_churn(32'd0, 3, 300);
		test_churn(32'd40, 20, 450);
		test_churn(TIMEOUT_RESET, 12000, 450);
		test_churn(32'hFFFF_FFFF, 1000, 200);
		test_churn($urandom, 32'h4000_0000, 300);
		wait_for_replies();
		repeat (80) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
hdl/cstir_pkg.sv
hdl/cstir_cell.sv
hdl/cstir_ctrl.sv
hdl/connection_slot_table_idle_reap.sv
sim/connection_slot_table_idle_reap_tb.sv
